// ===== rtl/gbn_pkg.sv =====
package gbn_pkg;

  // fixed field widths
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned SEQ_W    = 16;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned CHUNK_W  = 9;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned WIN_W    = 6;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned RETRY_W  = 4;
  localparam int unsigned CNT_W    = SEQ_W + 1;   // next_seq and base + 1 reach 65536
  localparam int unsigned OFF_W    = CNT_W + CHUNK_W;
  localparam int unsigned PC_W     = 5;
  localparam int unsigned PADDR_W  = 5;

  // clamps applied to the configuration
  localparam int unsigned MAX_WINDOW  = 32;
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned CHUNK_LIMIT = 511;

  // register reset values
  localparam logic [CHUNK_W-1:0] CHUNK_RST   = 9'd64;
  localparam logic [LEN_W-1:0]   LENGTH_RST  = 16'd1024;
  localparam logic [WIN_W-1:0]   WINDOW_RST  = 6'd8;
  localparam logic [TICK_W-1:0]  TIMEOUT_RST = 16'd3;
  localparam logic [RETRY_W-1:0] RETRIES_RST = 4'd10;

  // register indexes
  localparam logic [2:0] REG_CHUNK   = 3'd0;
  localparam logic [2:0] REG_LENGTH  = 3'd1;
  localparam logic [2:0] REG_WINDOW  = 3'd2;
  localparam logic [2:0] REG_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_RETRIES = 3'd4;

  // input opcodes
  localparam logic [OPCODE_W-1:0] OP_START = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ACK   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_DATA     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TERMINAL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NOTHING  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FINISHED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FAILED   = 3'd4;

  // transfer phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SEND = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;
  localparam logic [1:0] PH_FAIL = 2'd3;

  typedef enum logic [1:0] {
    W_NONE,
    W_IN,
    W_OUT
  } wait_e;

  typedef enum logic [3:0] {
    A_NONE,
    A_LATCH,
    A_START,
    A_ACK,
    A_TICK,
    A_GOBACK,
    A_MUL,
    A_EMIT_SEG,
    A_EMIT_NOTHING,
    A_EMIT_FINISH,
    A_EMIT_FAIL
  } act_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IS_START,
    C_IGNORE,
    C_IS_TICK,
    C_TEARDOWN,
    C_NOT_EXPIRED,
    C_RETRY_EXH,
    C_NO_SEG,
    C_NOT_LAST
  } cond_e;

  typedef struct packed {
    wait_e             waitc;
    act_e              act;
    cond_e             cond;
    logic [PC_W-1:0]   target;
  } uword_t;

  // program step addresses
  localparam logic [PC_W-1:0] S_FETCH    = 5'd0;
  localparam logic [PC_W-1:0] S_IS_START = 5'd1;
  localparam logic [PC_W-1:0] S_IGNORE   = 5'd2;
  localparam logic [PC_W-1:0] S_IS_TICK  = 5'd3;
  localparam logic [PC_W-1:0] S_TEARDOWN = 5'd4;
  localparam logic [PC_W-1:0] S_ACK      = 5'd5;
  localparam logic [PC_W-1:0] S_TICK     = 5'd6;
  localparam logic [PC_W-1:0] S_EXPIRED  = 5'd7;
  localparam logic [PC_W-1:0] S_RETRY    = 5'd8;
  localparam logic [PC_W-1:0] S_GOBACK   = 5'd9;
  localparam logic [PC_W-1:0] S_START    = 5'd10;
  localparam logic [PC_W-1:0] S_MUL      = 5'd11;
  localparam logic [PC_W-1:0] S_TEST     = 5'd12;
  localparam logic [PC_W-1:0] S_EMIT     = 5'd13;
  localparam logic [PC_W-1:0] S_RETURN   = 5'd14;
  localparam logic [PC_W-1:0] S_NOTHING  = 5'd15;
  localparam logic [PC_W-1:0] S_FINISH   = 5'd16;
  localparam logic [PC_W-1:0] S_FAIL     = 5'd17;

  // control store
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      S_FETCH:    w = '{W_IN,   A_LATCH,        C_NEVER,       S_FETCH};
      S_IS_START: w = '{W_NONE, A_NONE,         C_IS_START,    S_START};
      S_IGNORE:   w = '{W_NONE, A_NONE,         C_IGNORE,      S_NOTHING};
      S_IS_TICK:  w = '{W_NONE, A_NONE,         C_IS_TICK,     S_TICK};
      S_TEARDOWN: w = '{W_NONE, A_NONE,         C_TEARDOWN,    S_FINISH};
      S_ACK:      w = '{W_NONE, A_ACK,          C_ALWAYS,      S_MUL};
      S_TICK:     w = '{W_NONE, A_TICK,         C_NEVER,       S_FETCH};
      S_EXPIRED:  w = '{W_NONE, A_NONE,         C_NOT_EXPIRED, S_NOTHING};
      S_RETRY:    w = '{W_NONE, A_NONE,         C_RETRY_EXH,   S_FAIL};
      S_GOBACK:   w = '{W_NONE, A_GOBACK,       C_ALWAYS,      S_MUL};
      S_START:    w = '{W_NONE, A_START,        C_NEVER,       S_FETCH};
      S_MUL:      w = '{W_NONE, A_MUL,          C_NEVER,       S_FETCH};
      S_TEST:     w = '{W_NONE, A_NONE,         C_NO_SEG,      S_NOTHING};
      S_EMIT:     w = '{W_OUT,  A_EMIT_SEG,     C_NOT_LAST,    S_MUL};
      S_RETURN:   w = '{W_NONE, A_NONE,         C_ALWAYS,      S_FETCH};
      S_NOTHING:  w = '{W_OUT,  A_EMIT_NOTHING, C_ALWAYS,      S_FETCH};
      S_FINISH:   w = '{W_OUT,  A_EMIT_FINISH,  C_ALWAYS,      S_FETCH};
      S_FAIL:     w = '{W_OUT,  A_EMIT_FAIL,    C_ALWAYS,      S_FETCH};
      default:    w = '{W_NONE, A_NONE,         C_ALWAYS,      S_FETCH};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/gbn_in_if.sv =====
interface gbn_in_if;
  logic                             valid;
  logic                             ready;
  logic [gbn_pkg::OPCODE_W-1:0]     opcode;
  logic [gbn_pkg::SEQ_W-1:0]        ack_number;
  logic                             ack_is_teardown;

  modport source (output valid, opcode, ack_number, ack_is_teardown, input ready);
  modport sink   (input valid, opcode, ack_number, ack_is_teardown, output ready);
endinterface

// ===== rtl/gbn_out_if.sv =====
interface gbn_out_if;
  logic                             valid;
  logic                             ready;
  logic [gbn_pkg::KIND_W-1:0]       kind;
  logic [gbn_pkg::SEQ_W-1:0]        seq_number;
  logic [gbn_pkg::LEN_W-1:0]        byte_offset;
  logic [gbn_pkg::CHUNK_W-1:0]      byte_count;
  logic                             last;

  modport source (output valid, kind, seq_number, byte_offset, byte_count, last, input ready);
  modport sink   (input valid, kind, seq_number, byte_offset, byte_count, last, output ready);
endinterface

// ===== rtl/go_back_n_sender_window.sv =====
// an item is taken in the fetch step; its first result is registered in an emit step after the
//   decode steps for its kind (ignored, start, teardown, ack, go-back), once the output is free
// each segment sent passes the multiply, test and emit steps, plus any output stalls; a new item
//   is taken only after the last result of the previous one is registered
// segments are sent by the sequencer loop through the registered offset multiplier
// reset: asynchronous, registers return to their defaults, phase idle, sequencer at fetch
module go_back_n_sender_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gbn_in_if.sink                        in_i,
  gbn_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gbn_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned CNT_W = gbn_pkg::CNT_W;
  localparam int unsigned OFF_W = gbn_pkg::OFF_W;

  // configuration registers
  logic [gbn_pkg::CHUNK_W-1:0] chunk_q;
  logic [gbn_pkg::LEN_W-1:0]   length_q;
  logic [gbn_pkg::WIN_W-1:0]   window_q;
  logic [gbn_pkg::TICK_W-1:0]  timeout_q;
  logic [gbn_pkg::RETRY_W-1:0] retries_q;

  // latched transaction
  logic [gbn_pkg::OPCODE_W-1:0] op_q;
  logic [gbn_pkg::SEQ_W-1:0]    ack_q;
  logic                         td_q;

  // window state; base is kept as highest ack plus one so reset is zero
  logic [CNT_W-1:0]            base_p1_q;
  logic [CNT_W-1:0]            next_q;
  logic [gbn_pkg::RETRY_W-1:0] retry_q;
  logic [gbn_pkg::TICK_W-1:0]  tick_q;
  logic [1:0]                  phase_q;
  logic [OFF_W-1:0]            off_q;

  // sequencer
  logic [gbn_pkg::PC_W-1:0] pc_q, pc_d;
  gbn_pkg::uword_t          uw;
  logic                     go;
  logic                     cond_true;

  // output register
  logic                         ovalid_q;
  logic [gbn_pkg::KIND_W-1:0]   okind_q;
  logic [gbn_pkg::SEQ_W-1:0]    oseq_q;
  logic [gbn_pkg::LEN_W-1:0]    ooff_q;
  logic [gbn_pkg::CHUNK_W-1:0]  ocnt_q;
  logic                         olast_q;
  logic                         out_free;

  // effective configuration and segment tests
  logic [gbn_pkg::CHUNK_W-1:0] chunk_eff;
  logic [gbn_pkg::WIN_W-1:0]   win_eff;
  logic [CNT_W:0]              diff;
  logic                        win_ok;
  logic                        is_data;
  logic                        is_term;
  logic                        seg_last;
  logic [gbn_pkg::LEN_W-1:0]   remain;
  logic [gbn_pkg::CHUNK_W-1:0] seg_cnt;
  logic                        ack_ok;
  logic                        cfg_wr;
  logic [2:0]                  cfg_idx;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q   <= gbn_pkg::CHUNK_RST;
      length_q  <= gbn_pkg::LENGTH_RST;
      window_q  <= gbn_pkg::WINDOW_RST;
      timeout_q <= gbn_pkg::TIMEOUT_RST;
      retries_q <= gbn_pkg::RETRIES_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        gbn_pkg::REG_CHUNK:   chunk_q   <= pwdata[gbn_pkg::CHUNK_W-1:0];
        gbn_pkg::REG_LENGTH:  length_q  <= pwdata[gbn_pkg::LEN_W-1:0];
        gbn_pkg::REG_WINDOW:  window_q  <= pwdata[gbn_pkg::WIN_W-1:0];
        gbn_pkg::REG_TIMEOUT: timeout_q <= pwdata[gbn_pkg::TICK_W-1:0];
        gbn_pkg::REG_RETRIES: retries_q <= pwdata[gbn_pkg::RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      gbn_pkg::REG_CHUNK:   prdata = {{(32-gbn_pkg::CHUNK_W){1'b0}}, chunk_q};
      gbn_pkg::REG_LENGTH:  prdata = {{(32-gbn_pkg::LEN_W){1'b0}}, length_q};
      gbn_pkg::REG_WINDOW:  prdata = {{(32-gbn_pkg::WIN_W){1'b0}}, window_q};
      gbn_pkg::REG_TIMEOUT: prdata = {{(32-gbn_pkg::TICK_W){1'b0}}, timeout_q};
      gbn_pkg::REG_RETRIES: prdata = {{(32-gbn_pkg::RETRY_W){1'b0}}, retries_q};
      default:              prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- datapath terms
  // zero chunk acts as one, oversized chunk is clamped
  always_comb begin
    if (chunk_q == '0) begin
      chunk_eff = gbn_pkg::CHUNK_W'(1);
    end else if (32'(chunk_q) > gbn_pkg::CHUNK_LIMIT) begin
      chunk_eff = gbn_pkg::CHUNK_W'(gbn_pkg::CHUNK_LIMIT);
    end else begin
      chunk_eff = chunk_q;
    end
  end

  // zero window acts as one, clamp to window and result limits
  always_comb begin
    if (window_q == '0) begin
      win_eff = gbn_pkg::WIN_W'(1);
    end else if (32'(window_q) > gbn_pkg::MAX_WINDOW) begin
      win_eff = gbn_pkg::WIN_W'(gbn_pkg::MAX_WINDOW);
    end else if (32'(window_q) > gbn_pkg::MAX_RESULTS) begin
      win_eff = gbn_pkg::WIN_W'(gbn_pkg::MAX_RESULTS);
    end else begin
      win_eff = window_q;
    end
  end

  // segments outstanding beyond the highest ack, next is never below base + 1
  assign diff   = {1'b0, next_q} - {1'b0, base_p1_q};
  assign win_ok = diff < (CNT_W+1)'(win_eff);

  // off_q holds next * chunk: data while below the length, terminal when the
  // previous segment still started below the length
  assign is_data = off_q < OFF_W'(length_q);
  assign is_term = !is_data && (off_q < (OFF_W'(length_q) + OFF_W'(chunk_eff)));

  // a data segment always has a successor, so only the window can stop it
  assign seg_last = is_term || ((diff + (CNT_W+1)'(1)) >= (CNT_W+1)'(win_eff));

  assign remain  = length_q - off_q[gbn_pkg::LEN_W-1:0];
  assign seg_cnt = (remain < gbn_pkg::LEN_W'(chunk_eff)) ?
                   remain[gbn_pkg::CHUNK_W-1:0] : chunk_eff;

  // ack must be above the highest ack and below the next unsent number
  assign ack_ok = ({1'b0, ack_q} >= base_p1_q) && ({1'b0, ack_q} < next_q);

  // ---------------------------------------------------------------- sequencer
  assign uw       = gbn_pkg::ucode(pc_q);
  assign out_free = !ovalid_q || out_o.ready;

  always_comb begin
    case (uw.waitc)
      gbn_pkg::W_NONE: go = 1'b1;
      gbn_pkg::W_IN:   go = in_i.valid;
      gbn_pkg::W_OUT:  go = out_free;
      default:         go = 1'b1;
    endcase
  end

  always_comb begin
    case (uw.cond)
      gbn_pkg::C_NEVER:       cond_true = 1'b0;
      gbn_pkg::C_ALWAYS:      cond_true = 1'b1;
      gbn_pkg::C_IS_START:    cond_true = (op_q == gbn_pkg::OP_START);
      gbn_pkg::C_IGNORE:      cond_true = (op_q != gbn_pkg::OP_ACK && op_q != gbn_pkg::OP_TICK)
                                          || (phase_q != gbn_pkg::PH_SEND);
      gbn_pkg::C_IS_TICK:     cond_true = (op_q == gbn_pkg::OP_TICK);
      gbn_pkg::C_TEARDOWN:    cond_true = td_q;
      gbn_pkg::C_NOT_EXPIRED: cond_true = (tick_q < timeout_q);
      gbn_pkg::C_RETRY_EXH:   cond_true = (retry_q >= retries_q);
      gbn_pkg::C_NO_SEG:      cond_true = !win_ok || !(is_data || is_term);
      gbn_pkg::C_NOT_LAST:    cond_true = !seg_last;
      default:                cond_true = 1'b0;
    endcase
  end

  // a step that waits holds its address and suppresses its action
  always_comb begin
    if (!go) begin
      pc_d = pc_q;
    end else if (cond_true) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + gbn_pkg::PC_W'(1);
    end
  end

  // input is taken only in the fetch step
  assign in_i.ready = (uw.waitc == gbn_pkg::W_IN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= gbn_pkg::S_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  // latched transaction fields
  always_ff @(posedge clk_i) begin
    if (go && uw.act == gbn_pkg::A_LATCH) begin
      op_q  <= in_i.opcode;
      ack_q <= in_i.ack_number;
      td_q  <= in_i.ack_is_teardown;
    end
  end

  // offset multiplier, registered before the test step
  always_ff @(posedge clk_i) begin
    if (go && uw.act == gbn_pkg::A_MUL) begin
      off_q <= OFF_W'(next_q) * OFF_W'(chunk_eff);
    end
  end

  // window state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_p1_q <= '0;
      next_q    <= '0;
      retry_q   <= '0;
      tick_q    <= '0;
      phase_q   <= gbn_pkg::PH_IDLE;
    end else if (go) begin
      case (uw.act)
        gbn_pkg::A_START: begin
          base_p1_q <= '0;
          next_q    <= '0;
          retry_q   <= '0;
          tick_q    <= '0;
          phase_q   <= gbn_pkg::PH_SEND;
        end
        gbn_pkg::A_ACK: begin
          if (ack_ok) begin
            base_p1_q <= CNT_W'(ack_q) + CNT_W'(1);
            retry_q   <= '0;
            tick_q    <= '0;
          end
        end
        gbn_pkg::A_TICK: begin
          // saturating timer
          if (tick_q != '1) begin
            tick_q <= tick_q + gbn_pkg::TICK_W'(1);
          end
        end
        gbn_pkg::A_GOBACK: begin
          next_q  <= base_p1_q;
          tick_q  <= '0;
          retry_q <= retry_q + gbn_pkg::RETRY_W'(1);
        end
        gbn_pkg::A_EMIT_SEG: begin
          next_q <= next_q + CNT_W'(1);
        end
        gbn_pkg::A_EMIT_FINISH: phase_q <= gbn_pkg::PH_DONE;
        gbn_pkg::A_EMIT_FAIL:   phase_q <= gbn_pkg::PH_FAIL;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (go && (uw.act == gbn_pkg::A_EMIT_SEG || uw.act == gbn_pkg::A_EMIT_NOTHING ||
                        uw.act == gbn_pkg::A_EMIT_FINISH || uw.act == gbn_pkg::A_EMIT_FAIL)) begin
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      case (uw.act)
        gbn_pkg::A_EMIT_SEG: begin
          okind_q <= is_data ? gbn_pkg::KIND_DATA : gbn_pkg::KIND_TERMINAL;
          oseq_q  <= next_q[gbn_pkg::SEQ_W-1:0];
          ooff_q  <= is_data ? off_q[gbn_pkg::LEN_W-1:0] : length_q;
          ocnt_q  <= is_data ? seg_cnt : '0;
          olast_q <= seg_last;
        end
        gbn_pkg::A_EMIT_NOTHING, gbn_pkg::A_EMIT_FINISH, gbn_pkg::A_EMIT_FAIL: begin
          okind_q <= (uw.act == gbn_pkg::A_EMIT_NOTHING) ? gbn_pkg::KIND_NOTHING :
                     (uw.act == gbn_pkg::A_EMIT_FINISH)  ? gbn_pkg::KIND_FINISHED :
                                                           gbn_pkg::KIND_FAILED;
          oseq_q  <= '0;
          ooff_q  <= '0;
          ocnt_q  <= '0;
          olast_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.kind        = okind_q;
  assign out_o.seq_number  = oseq_q;
  assign out_o.byte_offset = ooff_q;
  assign out_o.byte_count  = ocnt_q;
  assign out_o.last        = olast_q;

endmodule

// ===== tb/sv/tb_go_back_n_sender_window.sv =====
`timescale 1ns / 100ps

module tb_go_back_n_sender_window;

  // opcode with no meaning for the block, it must answer with nothing sent
  localparam logic [gbn_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
  localparam int SETTLE_CYCLES = 12;     // idle wait after draining, so the sequencer returns to fetch
  localparam int DRAIN_LIMIT   = 20000;  // cycles to wait for outstanding results
  localparam int PHASE_ITEMS   = 56;     // counted items per random phase

  // one result transaction as seen on the output channel
  typedef struct packed {
    logic [gbn_pkg::KIND_W-1:0]  kind;
    logic [gbn_pkg::SEQ_W-1:0]   seq;
    logic [gbn_pkg::LEN_W-1:0]   offset;
    logic [gbn_pkg::CHUNK_W-1:0] count;
    logic                        last;
  } segment_t;

  // window predictor plus queue of segments still owed by the block
  class gbn_scoreboard;
    segment_t owed_q[$];
    segment_t item_q[$];
    int errors;

    // register copies
    logic [gbn_pkg::CHUNK_W-1:0] chunk_bytes;
    logic [gbn_pkg::LEN_W-1:0]   msg_bytes;
    logic [gbn_pkg::WIN_W-1:0]   window_segs;
    logic [gbn_pkg::TICK_W-1:0]  timeout_lim;
    logic [gbn_pkg::RETRY_W-1:0] retry_lim;

    // transfer state
    int         base_seq;
    int         next_seq;
    int         retries_used;
    int         ticks_waited;
    logic [1:0] xfer_phase;

    function new();
      errors       = 0;
      chunk_bytes  = gbn_pkg::CHUNK_RST;
      msg_bytes    = gbn_pkg::LENGTH_RST;
      window_segs  = gbn_pkg::WINDOW_RST;
      timeout_lim  = gbn_pkg::TIMEOUT_RST;
      retry_lim    = gbn_pkg::RETRIES_RST;
      base_seq     = -1;
      next_seq     = 0;
      retries_used = 0;
      ticks_waited = 0;
      xfer_phase   = gbn_pkg::PH_IDLE;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        gbn_pkg::REG_CHUNK:   chunk_bytes = val[gbn_pkg::CHUNK_W-1:0];
        gbn_pkg::REG_LENGTH:  msg_bytes   = val[gbn_pkg::LEN_W-1:0];
        gbn_pkg::REG_WINDOW:  window_segs = val[gbn_pkg::WIN_W-1:0];
        gbn_pkg::REG_TIMEOUT: timeout_lim = val[gbn_pkg::TICK_W-1:0];
        gbn_pkg::REG_RETRIES: retry_lim   = val[gbn_pkg::RETRY_W-1:0];
        default: ;
      endcase
    endfunction

    function int chunk_eff();
      int c;
      c = int'(chunk_bytes);
      if (c == 0) c = 1;
      if (c > int'(gbn_pkg::CHUNK_LIMIT)) c = int'(gbn_pkg::CHUNK_LIMIT);
      return c;
    endfunction

    // data segments plus the terminal one sit at numbers 0 .. seg_total()
    function int seg_total();
      return (int'(msg_bytes) + chunk_eff() - 1) / chunk_eff();
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void push_result(logic [gbn_pkg::KIND_W-1:0] k, int seq, int off, int cnt);
      segment_t s;
      s.kind   = k;
      s.seq    = gbn_pkg::SEQ_W'(seq);
      s.offset = gbn_pkg::LEN_W'(off);
      s.count  = gbn_pkg::CHUNK_W'(cnt);
      s.last   = 1'b0;
      item_q.push_back(s);
    endfunction

    function void fill_window();
      int c;
      int nseg;
      int w;
      int off;
      int rem;
      c    = chunk_eff();
      nseg = seg_total();
      w    = int'(window_segs);
      if (w == 0) w = 1;
      if (w > int'(gbn_pkg::MAX_WINDOW)) w = int'(gbn_pkg::MAX_WINDOW);
      if (w > int'(gbn_pkg::MAX_RESULTS)) w = int'(gbn_pkg::MAX_RESULTS);
      while (item_q.size() < int'(gbn_pkg::MAX_RESULTS) && next_seq <= nseg &&
             next_seq - base_seq <= w) begin
        if (next_seq == nseg) begin
          push_result(gbn_pkg::KIND_TERMINAL, next_seq, int'(msg_bytes), 0);
        end else begin
          off = next_seq * c;
          rem = int'(msg_bytes) - off;
          push_result(gbn_pkg::KIND_DATA, next_seq, off, (rem < c) ? rem : c);
        end
        next_seq++;
      end
    endfunction

    function void note_item(logic [gbn_pkg::OPCODE_W-1:0] op, logic [gbn_pkg::SEQ_W-1:0] ack,
                            logic teardown);
      item_q.delete();
      case (op)
        gbn_pkg::OP_START: begin
          base_seq     = -1;
          next_seq     = 0;
          retries_used = 0;
          ticks_waited = 0;
          xfer_phase   = gbn_pkg::PH_SEND;
          fill_window();
        end
        gbn_pkg::OP_ACK: begin
          if (xfer_phase != gbn_pkg::PH_SEND) begin
            push_result(gbn_pkg::KIND_NOTHING, 0, 0, 0);
          end else if (teardown) begin
            xfer_phase = gbn_pkg::PH_DONE;
            push_result(gbn_pkg::KIND_FINISHED, 0, 0, 0);
          end else begin
            if (int'(ack) > base_seq && int'(ack) < next_seq) begin
              base_seq     = int'(ack);
              retries_used = 0;
              ticks_waited = 0;
            end
            fill_window();
          end
        end
        gbn_pkg::OP_TICK: begin
          if (xfer_phase != gbn_pkg::PH_SEND) begin
            push_result(gbn_pkg::KIND_NOTHING, 0, 0, 0);
          end else begin
            if (ticks_waited < 'hFFFF) ticks_waited++;
            if (ticks_waited >= int'(timeout_lim)) begin
              if (retries_used >= int'(retry_lim)) begin
                xfer_phase = gbn_pkg::PH_FAIL;
                push_result(gbn_pkg::KIND_FAILED, 0, 0, 0);
              end else begin
                next_seq     = base_seq + 1;
                ticks_waited = 0;
                retries_used++;
                fill_window();
              end
            end
          end
        end
        default: push_result(gbn_pkg::KIND_NOTHING, 0, 0, 0);
      endcase
      if (item_q.size() == 0) push_result(gbn_pkg::KIND_NOTHING, 0, 0, 0);
      item_q[item_q.size()-1].last = 1'b1;
      foreach (item_q[i]) owed_q.push_back(item_q[i]);
    endfunction

    function void report(string what, segment_t exp, segment_t got);
      errors++;
      if (errors <= 10)
        $display({"%0t %s: exp kind %0d seq %0d off %0d cnt %0d last %0d,",
                  " got kind %0d seq %0d off %0d cnt %0d last %0d"},
                 $time, what, exp.kind, exp.seq, exp.offset, exp.count, exp.last,
                 got.kind, got.seq, got.offset, got.count, got.last);
    endfunction

    function void check_result(segment_t got);
      segment_t exp;
      if (owed_q.size() == 0) begin
        report("result with nothing owed", '0, got);
      end else begin
        exp = owed_q.pop_front();
        if (exp !== got) report("segment mismatch", exp, got);
      end
    endfunction

    function void flush_owed();
      while (owed_q.size() != 0) report("result never came", owed_q.pop_front(), '0);
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // apb side
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [gbn_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  gbn_in_if  in_if ();
  gbn_out_if out_if ();

  go_back_n_sender_window dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  gbn_scoreboard sb = new();

  // idle odds in percent per cycle, changed by the stimulus between phases
  int tx_idle_pct = 7;
  int rx_idle_pct = 78;
  // bumped by the stimulus to ask the receiver for one long hold-off
  int hold_req = 0;

  always #5 clk_i = ~clk_i;

  // receiver: random ready, or a long hold-off when asked for one
  initial begin : rx_proc
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // every output transaction is checked against the oldest owed segment
  always @(posedge clk_i) begin
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.check_result('{out_if.kind, out_if.seq_number, out_if.byte_offset,
                        out_if.byte_count, out_if.last});
  end

  // register i sits at byte address 4*i, written on the access cycle
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // offer one item, keep valid up until the block takes it
  task automatic send_item(input logic [gbn_pkg::OPCODE_W-1:0] op,
                           input logic [gbn_pkg::SEQ_W-1:0] ack,
                           input logic teardown);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.opcode          <= op;
    in_if.ack_number      <= ack;
    in_if.ack_is_teardown <= teardown;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_item(op, ack, teardown);
  endtask

  // stop offering, wait for every owed segment, then give the sequencer time to return
  task automatic settle();
    int waited;
    waited = 0;
    in_if.valid <= 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    sb.flush_owed();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // registers are only touched with the block idle
  task automatic configure(input logic [gbn_pkg::CHUNK_W-1:0] chunk,
                           input logic [gbn_pkg::LEN_W-1:0] len,
                           input logic [gbn_pkg::WIN_W-1:0] win,
                           input logic [gbn_pkg::TICK_W-1:0] tmo,
                           input logic [gbn_pkg::RETRY_W-1:0] retries);
    settle();
    reg_write(gbn_pkg::REG_CHUNK,   32'(chunk));
    reg_write(gbn_pkg::REG_LENGTH,  32'(len));
    reg_write(gbn_pkg::REG_WINDOW,  32'(win));
    reg_write(gbn_pkg::REG_TIMEOUT, 32'(tmo));
    reg_write(gbn_pkg::REG_RETRIES, 32'(retries));
  endtask

  // pick the next item from the predicted transfer state; mostly sane traffic:
  // starts when idle, acks inside the outstanding range, ticks to force go-backs,
  // teardown once the terminal segment is out, plus a little noise
  task automatic pick_and_send(output bit counts);
    logic [gbn_pkg::OPCODE_W-1:0] op;
    logic [gbn_pkg::SEQ_W-1:0]    ack;
    logic                         teardown;
    int                           r;
    op       = gbn_pkg::OP_TICK;
    ack      = gbn_pkg::SEQ_W'($urandom);
    teardown = 1'($urandom);
    r        = $urandom_range(99);
    counts   = 1'b1;
    if (sb.xfer_phase != gbn_pkg::PH_SEND) begin
      if (r < 75) begin
        op = gbn_pkg::OP_START;
      end else begin
        // ignored by the block while no transfer runs
        counts = 1'b0;
        if (r < 85) op = gbn_pkg::OP_ACK;
        else if (r < 95) op = gbn_pkg::OP_TICK;
        else op = OP_UNUSED;
      end
    end else if (sb.next_seq > sb.seg_total() && r < 40) begin
      op       = gbn_pkg::OP_ACK;
      teardown = 1'b1;
    end else if (r < 55) begin
      if (sb.next_seq > sb.base_seq + 1) begin
        op       = gbn_pkg::OP_ACK;
        teardown = 1'b0;
        if ($urandom_range(1) == 1) ack = gbn_pkg::SEQ_W'(sb.next_seq - 1);
        else ack = gbn_pkg::SEQ_W'($urandom_range(sb.next_seq - 1, sb.base_seq + 1));
      end
    end else if (r < 65) begin
      // ack with a random number, mostly outside the outstanding range
      op       = gbn_pkg::OP_ACK;
      teardown = 1'b0;
    end else if (r < 92) begin
      op = gbn_pkg::OP_TICK;
    end else if (r < 95) begin
      op       = gbn_pkg::OP_ACK;
      teardown = 1'b1;
    end else if (r < 98) begin
      op = gbn_pkg::OP_START;
    end else begin
      op     = OP_UNUSED;
      counts = 1'b0;
    end
    send_item(op, ack, teardown);
  endtask

  task automatic random_phase(input int n);
    int  counted;
    bit  hit;
    counted = 0;
    while (counted < n) begin
      pick_and_send(hit);
      if (hit) counted++;
    end
  endtask

  initial begin : stim
    in_if.valid           <= 1'b0;
    in_if.opcode          <= gbn_pkg::OP_START;
    in_if.ack_number      <= '0;
    in_if.ack_is_teardown <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed, reset register values: 16 data segments of 64 bytes, window 8
    // ack, tick and the unused opcode with no transfer running
    send_item(gbn_pkg::OP_TICK, 16'h0000, 1'b0);
    send_item(gbn_pkg::OP_ACK, 16'hFFFF, 1'b1);
    send_item(OP_UNUSED, 16'hFFFF, 1'b1);
    // start fills the window, an ack slides it
    send_item(gbn_pkg::OP_START, 16'h0000, 1'b0);
    send_item(gbn_pkg::OP_ACK, 16'd3, 1'b0);
    // stale ack and an ack beyond what was sent change nothing
    send_item(gbn_pkg::OP_ACK, 16'd3, 1'b0);
    send_item(gbn_pkg::OP_ACK, 16'hFFFF, 1'b0);
    // two quiet ticks, the third one times out and goes back to base plus one
    send_item(gbn_pkg::OP_TICK, 16'h0000, 1'b0);
    send_item(gbn_pkg::OP_TICK, 16'h0000, 1'b0);
    send_item(gbn_pkg::OP_TICK, 16'h0000, 1'b0);
    // last data segments plus the terminal one, then teardown
    send_item(gbn_pkg::OP_ACK, 16'd11, 1'b0);
    send_item(gbn_pkg::OP_ACK, 16'd0, 1'b1);
    send_item(gbn_pkg::OP_TICK, 16'h0000, 1'b0);
    // start after finishing, and start again in the middle of a transfer
    send_item(gbn_pkg::OP_START, 16'h0000, 1'b0);
    send_item(gbn_pkg::OP_START, 16'h0000, 1'b0);

    // empty message, zero window read as one: terminal segment only
    configure(9'd0, 16'd0, 6'd0, 16'd3, 4'd10);
    send_item(gbn_pkg::OP_START, 16'h0000, 1'b0);
    send_item(gbn_pkg::OP_ACK, 16'd0, 1'b0);

    // zero chunk read as one byte, window above the limit, zero timeout, no retries
    configure(9'd0, 16'hFFFF, 6'd63, 16'd0, 4'd0);
    send_item(gbn_pkg::OP_START, 16'h0000, 1'b0);
    send_item(gbn_pkg::OP_TICK, 16'h0000, 1'b0);
    send_item(gbn_pkg::OP_ACK, 16'd5, 1'b0);
    send_item(OP_UNUSED, 16'h0000, 1'b0);

    // largest chunk, window of one, timeout on every tick, most retries
    configure(9'd511, 16'd1000, 6'd1, 16'd1, 4'd15);
    send_item(gbn_pkg::OP_START, 16'h0000, 1'b0);
    send_item(gbn_pkg::OP_TICK, 16'h0000, 1'b0);
    send_item(gbn_pkg::OP_ACK, 16'd0, 1'b0);
    send_item(gbn_pkg::OP_ACK, 16'd1, 1'b0);

    // ---- random, sender rarely idle, receiver mostly stalling
    configure(gbn_pkg::CHUNK_RST, gbn_pkg::LENGTH_RST, gbn_pkg::WINDOW_RST,
              gbn_pkg::TIMEOUT_RST, gbn_pkg::RETRIES_RST);
    random_phase(PHASE_ITEMS);
    configure(9'd1, 16'd40, 6'd32, 16'd2, 4'd15);
    random_phase(PHASE_ITEMS);

    // ---- random, sender mostly idle, receiver rarely stalling
    configure(9'd511, 16'hFFFF, 6'd16, 16'd4, 4'd2);
    tx_idle_pct <= 78;
    rx_idle_pct <= 7;
    random_phase(PHASE_ITEMS);
    configure(gbn_pkg::CHUNK_W'($urandom_range(511, 1)),
              gbn_pkg::LEN_W'($urandom_range(4000, 1)),
              gbn_pkg::WIN_W'($urandom_range(32, 1)),
              gbn_pkg::TICK_W'($urandom_range(5, 1)),
              gbn_pkg::RETRY_W'($urandom_range(15, 0)));
    random_phase(PHASE_ITEMS);

    // ---- random, no idling; a long receiver hold-off backs the block up
    // while the sender keeps offering; ticks never time out in the first phase here
    configure(9'd100, 16'hFFFF, 6'd32, 16'hFFFF, 4'd3);
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    hold_req    <= hold_req + 1;
    random_phase(PHASE_ITEMS);
    configure(gbn_pkg::CHUNK_W'($urandom_range(511, 1)),
              gbn_pkg::LEN_W'($urandom_range(4000, 1)),
              gbn_pkg::WIN_W'($urandom_range(32, 1)), 16'd1,
              gbn_pkg::RETRY_W'($urandom_range(15, 0)));
    random_phase(PHASE_ITEMS);

    settle();
    if (sb.errors == 0) begin
      $display("tb_go_back_n_sender_window: done, clean");
    end else begin
      $display("tb_go_back_n_sender_window: done, errors");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin : watchdog
    #20ms;
    $display("tb_go_back_n_sender_window: done, errors");
    $finish;
  end

endmodule

// ===== go_back_n_sender_window.f =====
rtl/gbn_pkg.sv
rtl/gbn_in_if.sv
rtl/gbn_out_if.sv
rtl/go_back_n_sender_window.sv
tb/sv/tb_go_back_n_sender_window.sv
